// ----- src/cns_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductance neuron package
// Widths, operation codes, register indexes and fixed-point constants shared
// by the neuron step block, its multiplier and its checker.
// ----------------------------------------------------------------------------
package cns_pkg;

    // Field widths of the stream items.
    localparam int OP_W       = 2;
    localparam int DT_W       = 16;
    localparam int CUR_W      = 32;
    localparam int VOLT_W     = 25;
    localparam int COND_W     = 24;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;

    // Register port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Internal datapath widths.
    localparam int DIFF_W  = 26;
    localparam int ISYN_W  = 35;
    localparam int TOTAL_W = 36;
    localparam int DELTA_W = 37;
    localparam int NV_W    = 38;

    // Operation codes carried in tuser.
    localparam logic [OP_W-1:0] OP_STEP    = 2'd0;
    localparam logic [OP_W-1:0] OP_CURRENT = 2'd1;
    localparam logic [OP_W-1:0] OP_SPIKE   = 2'd2;

    // Register indexes (taken from paddr bit 2).
    localparam logic REG_RESTING = 1'b0;
    localparam logic REG_SYNAPSE = 1'b1;

    // Fixed-point constants, Q16.16 millivolts unless stated.
    localparam int V_LIMIT    = 13107200;
    localparam int V_FIRE     = 6553600;
    localparam int V_RESET    = -6553600;
    localparam int G_MAX      = 16777215;
    localparam int REST_RESET = -4259840;
    localparam int SYN_RESET  = 3276800;

endpackage

// ----- src/cns_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductance neuron shared multiplier
// Signed multiplier with a registered product, used in turn for the synaptic
// current, the conductance decay and the voltage update.
// ----------------------------------------------------------------------------
module cns_mul (
    input  logic                        clk,
    input  logic                        load,
    input  logic [cns_pkg::MUL_A_W-1:0] a,
    input  logic [cns_pkg::MUL_B_W-1:0] b,
    output logic [cns_pkg::MUL_P_W-1:0] product
);
    import cns_pkg::*;

    logic signed [MUL_P_W-1:0] product_next;
    logic [MUL_P_W-1:0]        product_reg;

    // Full signed product of the two operands.
    assign product_next = $signed(a) * $signed(b);

    // The product is held until the sequencer loads a new one.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ----- src/conductance_neuron_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductance neuron step
// Integrate-and-fire neuron with a synaptic conductance, in Q16.16 fixed
// point, driven by a stream of step, current and spike items.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_*: tuser carries the operation (step,
//   receive current, receive spike), tdata carries dt, other_current and
//   amount. Every item gives exactly one result item on m_axis_* with the
//   voltage, the conductance and the fired flag after the item.
//   Current and spike items are handled in the accepting cycle; their result
//   is valid in the next cycle, and one such item can be taken every cycle
//   while the receiver takes the results. For a step item one multiplier is
//   used three times in turn (synaptic current, conductance decay, voltage
//   update), then the voltage is clamped. The next item can be taken in the
//   cycle in which the result appears, if the receiver takes that result.
//   The block takes one item at a time: tready is low while a step is at
//   work, and new items are taken while a finished result is being drained.
//   If the receiver stalls, the result is held in the output register and
//   the next result waits for it; no item is lost.
//   The APB port writes the resting and synaptic reversal potentials, which
//   may only change while the block is idle. Reset restores the sequencer,
//   neuron state and both registers and empties the output register.
// ----------------------------------------------------------------------------
module conductance_neuron_step (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input item stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: dt[15:0], other_current[47:16], amount[79:48]
    input  logic [cns_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op[1:0]
    input  logic [cns_pkg::OP_W-1:0]       s_axis_tuser,
    // Result item stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: voltage[24:0], conductance[48:25], fired[49], zero[55:50]
    output logic [cns_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cns_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cns_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cns_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cns_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SYN    = 3'd1;
    localparam logic [2:0] ST_DECAY  = 3'd2;
    localparam logic [2:0] ST_VOLT   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic signed [VOLT_W-1:0] volt_reg, volt_next;
    logic [COND_W-1:0]        cond_reg, cond_next;
    logic [CUR_W-1:0]         sum_reg, sum_next;
    logic                     fired_last_reg, fired_last_next;
    logic signed [VOLT_W-1:0] rest_reg, rest_next;
    logic signed [VOLT_W-1:0] syn_reg, syn_next;
    logic                     out_valid_reg, out_valid_next;

    logic [DT_W-1:0]          dt_reg, dt_next;
    logic [CUR_W-1:0]         other_reg, other_next;
    logic [DIFF_W-1:0]        diff_reg, diff_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic                     fired_now_reg, fired_now_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;

    logic [OP_W-1:0]          in_op;
    logic [DT_W-1:0]          in_dt;
    logic [CUR_W-1:0]         in_other;
    logic [CUR_W-1:0]         in_amount;
    logic                     in_accept;
    logic                     out_free;
    logic                     cfg_write;

    logic signed [VOLT_W-1:0] volt_rec;
    logic [COND_W-1:0]        cond_rec;
    logic                     fire_now;
    logic                     fired_last_rec;
    logic [CUR_W:0]           sum_wide;
    logic [CUR_W+1:0]         cond_wide;
    logic [ISYN_W+15:0]       neg_syn;
    logic [ISYN_W-1:0]        isyn;
    logic [DELTA_W-1:0]       delta;
    logic signed [NV_W-1:0]   nv_wide;
    logic signed [VOLT_W-1:0] volt_clamped;

    logic                     mul_load;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]       mul_product;

    // Unpack the input item.
    assign in_op     = s_axis_tuser;
    assign in_dt     = s_axis_tdata[15:0];
    assign in_other  = s_axis_tdata[47:16];
    assign in_amount = s_axis_tdata[79:48];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_write     = psel && penable && pwrite;

    // Register read-back, sign-extended to the bus width.
    assign pready = 1'b1;
    always_comb
    begin
        if (paddr[2] == REG_SYNAPSE)
        begin
            prdata = {{(CFG_DATA_W-VOLT_W){syn_reg[VOLT_W-1]}}, syn_reg};
        end
        else
        begin
            prdata = {{(CFG_DATA_W-VOLT_W){rest_reg[VOLT_W-1]}}, rest_reg};
        end
    end

    // Spike recovery or firing at the start of a step.
    always_comb
    begin
        volt_rec       = volt_reg;
        cond_rec       = cond_reg;
        fire_now       = 1'b0;
        fired_last_rec = fired_last_reg;
        if (fired_last_reg)
        begin
            volt_rec       = rest_reg;
            fired_last_rec = 1'b0;
        end
        else if (volt_reg > 0)
        begin
            volt_rec       = VOLT_W'(V_FIRE);
            cond_rec       = '0;
            fire_now       = 1'b1;
            fired_last_rec = 1'b1;
        end
    end

    // Saturating sums for the current and spike items.
    assign sum_wide  = {sum_reg[CUR_W-1], sum_reg} + {in_amount[CUR_W-1], in_amount};
    assign cond_wide = {2'b00, 8'h00, cond_reg} + {{2{in_amount[CUR_W-1]}}, in_amount};

    // Synaptic current: negated product, rounded toward minus infinity.
    assign neg_syn = (ISYN_W+16)'(0) - {mul_product[ISYN_W+14], mul_product[ISYN_W+14:0]};
    assign isyn    = neg_syn[ISYN_W+15:16];

    // Voltage update and clamp.
    assign delta   = mul_product[DELTA_W+15:16];
    assign nv_wide = $signed({{(NV_W-VOLT_W){volt_reg[VOLT_W-1]}}, volt_reg})
                   + $signed({delta[DELTA_W-1], delta});
    always_comb
    begin
        if (nv_wide > NV_W'(V_LIMIT))
        begin
            volt_clamped = VOLT_W'(V_LIMIT);
        end
        else if (nv_wide < NV_W'(-V_LIMIT))
        begin
            volt_clamped = VOLT_W'(-V_LIMIT);
        end
        else
        begin
            volt_clamped = nv_wide[VOLT_W-1:0];
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_load = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_SYN:
            begin
                mul_load = 1'b1;
                mul_a    = {{(MUL_A_W-COND_W){1'b0}}, cond_reg};
                mul_b    = diff_reg;
            end
            ST_DECAY:
            begin
                mul_load = 1'b1;
                mul_a    = {{(MUL_A_W-COND_W){1'b0}}, cond_reg};
                mul_b    = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            ST_VOLT:
            begin
                mul_load = 1'b1;
                mul_a    = total_reg;
                mul_b    = {{(MUL_B_W-DT_W){1'b0}}, dt_reg};
            end
            default:
            begin
                mul_load = 1'b0;
            end
        endcase
    end

    cns_mul u_mul (
        .clk     (clk),
        .load    (mul_load),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product)
    );

    // Sequencer and state update.
    always_comb
    begin
        state_next      = state_reg;
        volt_next       = volt_reg;
        cond_next       = cond_reg;
        sum_next        = sum_reg;
        fired_last_next = fired_last_reg;
        rest_next       = rest_reg;
        syn_next        = syn_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        dt_next         = dt_reg;
        other_next      = other_reg;
        diff_next       = diff_reg;
        total_next      = total_reg;
        fired_now_next  = fired_now_reg;
        out_data_next   = out_data_reg;

        if (cfg_write)
        begin
            if (paddr[2] == REG_SYNAPSE)
            begin
                syn_next = pwdata[VOLT_W-1:0];
            end
            else
            begin
                rest_next = pwdata[VOLT_W-1:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_op)
                        OP_STEP:
                        begin
                            volt_next       = volt_rec;
                            cond_next       = cond_rec;
                            fired_last_next = fired_last_rec;
                            fired_now_next  = fire_now;
                            dt_next         = in_dt;
                            other_next      = in_other;
                            diff_next       = {volt_rec[VOLT_W-1], volt_rec}
                                            - {syn_reg[VOLT_W-1], syn_reg};
                            state_next      = ST_SYN;
                        end
                        OP_CURRENT:
                        begin
                            if (sum_wide[CUR_W] != sum_wide[CUR_W-1])
                            begin
                                sum_next = {sum_wide[CUR_W], {(CUR_W-1){!sum_wide[CUR_W]}}};
                            end
                            else
                            begin
                                sum_next = sum_wide[CUR_W-1:0];
                            end
                            out_valid_next = 1'b1;
                            out_data_next  = {6'b0, 1'b0, cond_reg, volt_reg};
                        end
                        OP_SPIKE:
                        begin
                            if (cond_wide[CUR_W+1])
                            begin
                                cond_next = '0;
                            end
                            else if (cond_wide[CUR_W:COND_W] != '0)
                            begin
                                cond_next = COND_W'(G_MAX);
                            end
                            else
                            begin
                                cond_next = cond_wide[COND_W-1:0];
                            end
                            out_valid_next = 1'b1;
                            out_data_next  = {6'b0, 1'b0, cond_next, volt_reg};
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = {6'b0, 1'b0, cond_reg, volt_reg};
                        end
                    endcase
                end
            end
            ST_SYN:
            begin
                state_next = ST_DECAY;
            end
            ST_DECAY:
            begin
                // Product holds g*(V - Es); form the total membrane current.
                total_next = {isyn[ISYN_W-1], isyn}
                           + {{(TOTAL_W-CUR_W){other_reg[CUR_W-1]}}, other_reg}
                           + {{(TOTAL_W-CUR_W){sum_reg[CUR_W-1]}}, sum_reg};
                sum_next   = '0;
                state_next = ST_VOLT;
            end
            ST_VOLT:
            begin
                // Product holds g*dt; apply the conductance decay.
                cond_next  = cond_reg - mul_product[COND_W+15:16];
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    volt_next      = volt_clamped;
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, fired_now_reg, cond_reg, volt_clamped};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and neuron state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            volt_reg       <= VOLT_W'(V_RESET);
            cond_reg       <= '0;
            sum_reg        <= '0;
            fired_last_reg <= 1'b0;
            rest_reg       <= VOLT_W'(REST_RESET);
            syn_reg        <= VOLT_W'(SYN_RESET);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            volt_reg       <= volt_next;
            cond_reg       <= cond_next;
            sum_reg        <= sum_next;
            fired_last_reg <= fired_last_next;
            rest_reg       <= rest_next;
            syn_reg        <= syn_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        dt_reg        <= dt_next;
        other_reg     <= other_next;
        diff_reg      <= diff_next;
        total_reg     <= total_next;
        fired_now_reg <= fired_now_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- src/cns_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conductance neuron checker
// Port-level assertions on the neuron step block, attached by a bind.
// ----------------------------------------------------------------------------
module cns_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cns_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import cns_pkg::*;

    // A stalled result item keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

    // An item is only taken when the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("item accepted while a result was blocked");

    // Every reported voltage lies within the clamp range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[24:0]) <= V_LIMIT
                       && $signed(m_axis_tdata[24:0]) >= -V_LIMIT)
    else $error("voltage outside the clamp range");

    // Firing clears the conductance, and decay keeps it at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[49] |-> m_axis_tdata[48:25] == '0)
    else $error("conductance not cleared on firing");

endmodule

bind conductance_neuron_step cns_checker u_cns_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
